@@ hdl/mhb_pkg.sv @@
// mhb_pkg: shared types and constants for the murmur hash 64b block
// no dependencies; used by the multiplier unit and the top level

package mhb_pkg;

   typedef logic [31:0] word_type;

   // mixing multiplier and word mix shift
   localparam word_type MIX_MULT  = 32'h5bd1_e995;
   localparam int       MIX_SHIFT = 24;

   // cross-lane shifts of the four finalization rounds
   localparam int FIN_SHIFT_0 = 18;
   localparam int FIN_SHIFT_1 = 22;
   localparam int FIN_SHIFT_2 = 17;
   localparam int FIN_SHIFT_3 = 19;

endpackage

@@ hdl/mhb_mult_unit.sv @@
// mhb_mult_unit: shared 32-bit multiplier by the mixing constant, result registered
// depends on mhb_pkg

module mhb_mult_unit (
   input  logic               clock,
   input  logic               mult_en,
   input  mhb_pkg::word_type  operand,
   output mhb_pkg::word_type  product
);

   mhb_pkg::word_type product_ff;
   mhb_pkg::word_type product_in;

   // only the low word is kept, arithmetic is modulo 2^32
   assign product_in = mult_en ? operand * mhb_pkg::MIX_MULT : product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ hdl/murmur_hash_64b.sv @@
// Streaming 64-bit MurmurHash2 (variant B). One little-endian 32-bit word is taken per item;
// the item that ends a message produces one 64-bit hash with lane A in bits 63:32 and lane B
// in bits 31:0. All multiplies go through one registered 32x32 multiplier under a small
// sequencer, so the block works on one item at a time: an item with a full word passes
// through accept, three multiplies and the lane update, a 1-3 byte tail through accept,
// one multiply and the lane update, an item with no data through accept only. An item that
// ends a message then runs finalization (four rounds of multiply and write back) and hands
// the hash to the output register, waiting while a previous hash still waits there.
// The seed written through csr_wr_en/csr_wr_data is used at the next first item.
// depends on mhb_pkg and mhb_mult_unit

module murmur_hash_64b (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_word[31:0], valid_bytes[34:32],
                                    // total_length[65:35], zero[71:66]
   input  logic        req_tuser,   // first_item
   input  logic        req_tlast,   // last_item
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // hash_value[63:0]
   // seed register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MIX1    = 4'd1;
   localparam logic [3:0] ST_MIX2    = 4'd2;
   localparam logic [3:0] ST_MIX3    = 4'd3;
   localparam logic [3:0] ST_MIX4    = 4'd4;
   localparam logic [3:0] ST_TAIL1   = 4'd5;
   localparam logic [3:0] ST_TAIL2   = 4'd6;
   localparam logic [3:0] ST_FIN_MUL = 4'd7;
   localparam logic [3:0] ST_FIN_WR  = 4'd8;
   localparam logic [3:0] ST_FIN_OUT = 4'd9;

   logic [3:0]        state_ff, state_in;
   mhb_pkg::word_type seed_ff, seed_in;
   mhb_pkg::word_type lane_a_ff, lane_a_in;
   mhb_pkg::word_type lane_b_ff, lane_b_in;
   logic              odd_ff, odd_in;
   logic [1:0]        round_ff, round_in;
   mhb_pkg::word_type word_ff, word_in;
   logic [1:0]        nbytes_ff, nbytes_in;
   logic              last_ff, last_in;
   mhb_pkg::word_type k_ff, k_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]       rsp_tdata_ff, rsp_tdata_in;

   logic              mult_en;
   mhb_pkg::word_type mult_operand;
   mhb_pkg::word_type product;
   mhb_pkg::word_type tail_mask;
   mhb_pkg::word_type fin_operand;

   mhb_mult_unit u_mult (
      .clock   (clock),
      .mult_en (mult_en),
      .operand (mult_operand),
      .product (product)
   );

   always_comb begin
      case (nbytes_ff)
         2'd1:    tail_mask = 32'h0000_00ff;
         2'd2:    tail_mask = 32'h0000_ffff;
         2'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'h0000_0000;
      endcase
   end

   // even rounds fold lane b into a, odd rounds fold lane a into b
   always_comb begin
      case (round_ff)
         2'd0:    fin_operand = lane_a_ff ^ (lane_b_ff >> mhb_pkg::FIN_SHIFT_0);
         2'd1:    fin_operand = lane_b_ff ^ (lane_a_ff >> mhb_pkg::FIN_SHIFT_1);
         2'd2:    fin_operand = lane_a_ff ^ (lane_b_ff >> mhb_pkg::FIN_SHIFT_2);
         default: fin_operand = lane_b_ff ^ (lane_a_ff >> mhb_pkg::FIN_SHIFT_3);
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      seed_in       = csr_wr_en ? csr_wr_data : seed_ff;
      lane_a_in     = lane_a_ff;
      lane_b_in     = lane_b_ff;
      odd_in        = odd_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      nbytes_in     = nbytes_ff;
      last_in       = last_ff;
      k_in          = k_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mult_en       = 1'b0;
      mult_operand  = 32'h0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in   = req_tdata[31:0];
               nbytes_in = req_tdata[33:32];
               last_in   = req_tlast;
               round_in  = 2'd0;
               if (req_tuser) begin
                  lane_a_in = seed_ff ^ {1'b0, req_tdata[65:35]};
                  lane_b_in = 32'h0;
                  odd_in    = 1'b0;
               end
               // counts above four count as a full word
               if (req_tdata[34]) begin
                  state_in = ST_MIX1;
               end else if (req_tdata[33:32] != 2'd0) begin
                  state_in = ST_TAIL1;
               end else if (req_tlast) begin
                  state_in = ST_FIN_MUL;
               end
            end
         end
         ST_MIX1: begin
            mult_en      = 1'b1;
            mult_operand = word_ff;
            state_in     = ST_MIX2;
         end
         ST_MIX2: begin
            mult_en      = 1'b1;
            mult_operand = product ^ (product >> mhb_pkg::MIX_SHIFT);
            state_in     = ST_MIX3;
         end
         ST_MIX3: begin
            k_in         = product;
            mult_en      = 1'b1;
            mult_operand = odd_ff ? lane_b_ff : lane_a_ff;
            state_in     = ST_MIX4;
         end
         ST_MIX4: begin
            if (odd_ff) begin
               lane_b_in = product ^ k_ff;
            end else begin
               lane_a_in = product ^ k_ff;
            end
            odd_in   = ~odd_ff;
            state_in = last_ff ? ST_FIN_MUL : ST_IDLE;
         end
         ST_TAIL1: begin
            mult_en      = 1'b1;
            mult_operand = lane_b_ff ^ (word_ff & tail_mask);
            state_in     = ST_TAIL2;
         end
         ST_TAIL2: begin
            lane_b_in = product;
            state_in  = last_ff ? ST_FIN_MUL : ST_IDLE;
         end
         ST_FIN_MUL: begin
            mult_en      = 1'b1;
            mult_operand = fin_operand;
            state_in     = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            if (round_ff[0]) begin
               lane_b_in = product;
            end else begin
               lane_a_in = product;
            end
            round_in = round_ff + 2'd1;
            state_in = (round_ff == 2'd3) ? ST_FIN_OUT : ST_FIN_MUL;
         end
         ST_FIN_OUT: begin
            // wait for the output register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {lane_a_ff, lane_b_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seed_ff       <= 32'h0;
         lane_a_ff     <= 32'h0;
         lane_b_ff     <= 32'h0;
         odd_ff        <= 1'b0;
         round_ff      <= 2'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seed_ff       <= seed_in;
         lane_a_ff     <= lane_a_in;
         lane_b_ff     <= lane_b_in;
         odd_ff        <= odd_in;
         round_ff      <= round_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      nbytes_ff    <= nbytes_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ hdl/mhb_checker.sv @@
// mhb_checker: port-level assertions for murmur_hash_64b, bound to the top level
// depends on the port list of murmur_hash_64b

module mhb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled hash stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // an idle block stays ready until an item arrives
   assert property (@(posedge clock) disable iff (reset)
      req_tready && !req_tvalid |=> req_tready)
      else $error("ready dropped with no item accepted");

   // a hash only appears at the end of finalization, never from idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("hash appeared without finalization");

   // reset leaves the block idle with no pending hash
   assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind murmur_hash_64b mhb_checker u_mhb_checker (.*);

@@ verif/tb_murmur_hash_64b.sv @@
`timescale 1ns / 100ps
// tb_murmur_hash_64b: self-checking testbench for the streaming 64-bit murmur hash block
// a directed table and random messages are predicted in the bench and checked per item;
// depends on mhb_pkg and the murmur_hash_64b rtl

module tb_murmur_hash_64b;

   localparam int STUCK_LIMIT  = 4000;
   localparam int SETTLE_TICKS = 30;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        first;
      logic        last;
      logic [30:0] total;
      logic        known;
      logic [63:0] hash;
   } hash_row_type;

   typedef struct packed {
      logic        known;
      logic [63:0] hash;
   } typed_hash_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // data_word[31:0], valid_bytes[34:32],
                             // total_length[65:35], zero[71:66]
   logic        req_tuser;   // first_item
   logic        req_tlast;   // last_item
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // hash_value[63:0]
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   // bench copy of the hash state
   logic [31:0] seed_reg = '0;
   logic [31:0] lane_a = '0;
   logic [31:0] lane_b = '0;
   logic        odd_word = 1'b0;

   logic [63:0]    hash_q[$];
   typed_hash_type note_q[$];

   int item_count = 0;
   int message_count = 0;
   int hash_count = 0;
   int err_count = 0;
   int stuck_cycles = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_req = 1'b0;

   murmur_hash_64b u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic mhb_pkg::word_type mix_word(mhb_pkg::word_type k);
      k = k * mhb_pkg::MIX_MULT;
      k = k ^ (k >> mhb_pkg::MIX_SHIFT);
      k = k * mhb_pkg::MIX_MULT;
      return k;
   endfunction

   function void murmur_absorb(logic [31:0] word, logic [2:0] nbytes, logic first,
                               logic [30:0] total);
      logic [31:0] mask;
      if (first) begin
         lane_a   = seed_reg ^ {1'b0, total};
         lane_b   = '0;
         odd_word = 1'b0;
      end
      if (nbytes >= 3'd4) begin
         if (!odd_word) lane_a = (lane_a * mhb_pkg::MIX_MULT) ^ mix_word(word);
         else lane_b = (lane_b * mhb_pkg::MIX_MULT) ^ mix_word(word);
         odd_word = ~odd_word;
      end else if (nbytes != 3'd0) begin
         case (nbytes)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            default: mask = 32'h00ff_ffff;
         endcase
         lane_b = (lane_b ^ (word & mask)) * mhb_pkg::MIX_MULT;
      end
   endfunction

   function logic [63:0] murmur_finish();
      lane_a = (lane_a ^ (lane_b >> mhb_pkg::FIN_SHIFT_0)) * mhb_pkg::MIX_MULT;
      lane_b = (lane_b ^ (lane_a >> mhb_pkg::FIN_SHIFT_1)) * mhb_pkg::MIX_MULT;
      lane_a = (lane_a ^ (lane_b >> mhb_pkg::FIN_SHIFT_2)) * mhb_pkg::MIX_MULT;
      lane_b = (lane_b ^ (lane_a >> mhb_pkg::FIN_SHIFT_3)) * mhb_pkg::MIX_MULT;
      return {lane_a, lane_b};
   endfunction

   // result check first, then seed writes and accepted items feed the predictor
   always @(posedge clock) begin : monitor_blk
      typed_hash_type note;
      logic [63:0] predicted;
      logic [63:0] wanted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (hash_q.size() == 0) begin
               $display("%0t: unexpected hash %h, none expected", $time, rsp_tdata);
               err_count++;
            end else begin
               wanted = hash_q.pop_front();
               hash_count++;
               if (rsp_tdata !== wanted) begin
                  $display("%0t: hash mismatch, expected %h, actual %h",
                           $time, wanted, rsp_tdata);
                  err_count++;
               end
            end
         end
         if (csr_wr_en) seed_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            item_count++;
            note = note_q.pop_front();
            if (req_tuser) message_count++;
            murmur_absorb(req_tdata[31:0], req_tdata[34:32], req_tuser, req_tdata[65:35]);
            if (req_tlast) begin
               predicted = murmur_finish();
               hash_q.push_back(note.known ? note.hash : predicted);
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver_blk
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic first, input logic last, input logic [30:0] total,
                            input logic known, input logic [63:0] hash);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note_q.push_back({known, hash});
      req_tdata  <= {6'd0, total, nbytes, word};
      req_tuser  <= first;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // one well-formed message of random length and content
   task automatic send_message();
      int pick, len, n_items, i;
      logic [30:0] total;
      logic [2:0] nb;
      logic is_last;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(16);
      else if (pick < 95) len = $urandom_range(64, 17);
      else len = $urandom_range(200, 65);
      // occasionally a length that does not match the data
      total = ($urandom_range(9) == 0) ? 31'($urandom) : 31'(len);
      if (len == 0) begin
         send_item($urandom, 3'd0, 1'b1, 1'b1, total, 1'b0, '0);
      end else begin
         n_items = (len + 3) / 4;
         for (i = 0; i < n_items; i++) begin
            is_last = (i == n_items - 1);
            if (is_last && (len % 4) != 0) nb = 3'(len % 4);
            else if ($urandom_range(9) == 0) nb = 3'($urandom_range(7, 5));
            else nb = 3'd4;
            if (i > 0 && $urandom_range(19) == 0)
               send_item($urandom, 3'd0, 1'b0, 1'b0, 31'($urandom), 1'b0, '0);
            send_item($urandom, nb, (i == 0), is_last, total, 1'b0, '0);
         end
      end
   endtask

   // one edge first so the last accepted item has reached the predictor
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus_blk
      hash_row_type dir_rows[25];
      int r, phase, target;
      bit hold_sent;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      // word, bytes, first, last, total, typed-in, hash
      dir_rows[0]  = {32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'd0, 1'b1, 64'h0}; // lanes from reset
      dir_rows[1]  = {32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'd0, 1'b1, 64'h0}; // empty message
      dir_rows[2]  = {32'hffff_ffff, 3'd4, 1'b1, 1'b1, 31'd4, 1'b0, 64'h0};
      dir_rows[3]  = {32'h0000_0000, 3'd4, 1'b1, 1'b1, 31'd4, 1'b0, 64'h0};
      dir_rows[4]  = {32'hffff_ff5a, 3'd1, 1'b1, 1'b1, 31'd1, 1'b0, 64'h0}; // junk above tail
      dir_rows[5]  = {32'hdead_beef, 3'd2, 1'b1, 1'b1, 31'd2, 1'b0, 64'h0};
      dir_rows[6]  = {32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3, 1'b0, 64'h0};
      dir_rows[7]  = {32'h1234_5678, 3'd5, 1'b1, 1'b1, 31'd4, 1'b0, 64'h0}; // oversized count
      dir_rows[8]  = {32'h8765_4321, 3'd7, 1'b1, 1'b1, 31'd4, 1'b0, 64'h0};
      dir_rows[9]  = {32'h0403_0201, 3'd4, 1'b1, 1'b0, 31'd15, 1'b0, 64'h0};
      dir_rows[10] = {32'h0807_0605, 3'd4, 1'b0, 1'b0, 31'd15, 1'b0, 64'h0};
      dir_rows[11] = {32'h0c0b_0a09, 3'd4, 1'b0, 1'b0, 31'd15, 1'b0, 64'h0};
      dir_rows[12] = {32'hff0f_0e0d, 3'd3, 1'b0, 1'b1, 31'd15, 1'b0, 64'h0};
      dir_rows[13] = {32'hcafe_babe, 3'd2, 1'b1, 1'b0, 31'd10, 1'b0, 64'h0}; // tail mid-message
      dir_rows[14] = {32'h1111_1111, 3'd4, 1'b0, 1'b0, 31'd10, 1'b0, 64'h0};
      dir_rows[15] = {32'hffff_ffff, 3'd0, 1'b0, 1'b0, 31'd10, 1'b0, 64'h0}; // no data
      dir_rows[16] = {32'h2222_2222, 3'd4, 1'b0, 1'b1, 31'd10, 1'b0, 64'h0};
      dir_rows[17] = {32'h3333_3333, 3'd4, 1'b0, 1'b0, 31'd0, 1'b0, 64'h0};  // no first item
      dir_rows[18] = {32'h4444_4444, 3'd6, 1'b0, 1'b1, 31'd0, 1'b0, 64'h0};
      dir_rows[19] = {32'h8000_0001, 3'd4, 1'b1, 1'b1, 31'h7fff_ffff, 1'b0, 64'h0};
      dir_rows[20] = {32'h5555_5555, 3'd4, 1'b1, 1'b0, 31'd8, 1'b0, 64'h0};
      dir_rows[21] = {32'haaaa_aaaa, 3'd4, 1'b0, 1'b0, 31'd8, 1'b0, 64'h0};
      dir_rows[22] = {32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'd8, 1'b0, 64'h0};  // empty last item
      dir_rows[23] = {32'h6666_6666, 3'd4, 1'b1, 1'b0, 31'd12, 1'b0, 64'h0}; // restarted below
      dir_rows[24] = {32'h7777_7777, 3'd1, 1'b1, 1'b1, 31'd1, 1'b0, 64'h0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 24;
      rx_idle_pct = 74;
      csr_write(32'h0000_0000);
      for (r = 0; r < 25; r++)
         send_item(dir_rows[r].word, dir_rows[r].nbytes, dir_rows[r].first, dir_rows[r].last,
                   dir_rows[r].total, dir_rows[r].known, dir_rows[r].hash);
      drain();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 24;
               rx_idle_pct = 74;
               csr_write(32'hffff_ffff);
            end
            1: begin
               tx_idle_pct = 74;
               rx_idle_pct = 24;
               csr_write($urandom);
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               csr_write($urandom);
            end
         endcase
         target = item_count + 490;
         hold_sent = 1'b0;
         while (item_count < target) begin
            // long receiver hold-off while the sender keeps pushing
            if (phase == 2 && !hold_sent && item_count > target - 400) begin
               hold_req = 1'b1;
               hold_sent = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(3, 1))
                  send_item($urandom, 3'($urandom_range(7)), ($urandom_range(4) == 0),
                            ($urandom_range(4) == 0), 31'($urandom), 1'b0, '0);
            end else begin
               send_message();
            end
         end
         send_message();
         drain();
      end

      $display("%0d items in %0d messages, %0d hashes checked", item_count, message_count,
               hash_count);
      $display("seeds zero, all ones and random; tails, oversized counts, restarts, stalls");
      if (err_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
